// ===== hdl/ordered_list_buffer_assert.svh =====
// Assertion macros shared by the ordered list buffer RTL.
// OLB_ASSERT is checked outside reset, OLB_ASSERT_ALWAYS at every clock edge.
`ifndef ORDERED_LIST_BUFFER_ASSERT_SVH
`define ORDERED_LIST_BUFFER_ASSERT_SVH

`ifndef SYNTHESIS

`define OLB_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ordered_list_buffer: assertion failed");

`define OLB_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ordered_list_buffer: assertion failed");

`else

`define OLB_ASSERT(label, prop)

`define OLB_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ===== hdl/olb_pkg.sv =====
package olb_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Field widths of the stream items.
    localparam int CMD_W  = 3;
    localparam int POS_W  = 7;
    localparam int FPOS_W = 7;
    localparam int STAT_W = 3;
    localparam int LEN_W  = 7;

    localparam int S_FIELDS_W = CMD_W + POS_W + DATA_WIDTH;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = DATA_WIDTH + FPOS_W + STAT_W + LEN_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(CAPACITY - 1);
    localparam logic [FPOS_W-1:0] NO_POS     = '1;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd5;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd6;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADIDX   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

    // Operations broadcast to every cell of the row.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_HOLD = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD = 3'd1;
    localparam logic [OP_W-1:0] OP_INS  = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL  = 3'd3;
    localparam logic [OP_W-1:0] OP_CMP  = 3'd4;
    localparam logic [OP_W-1:0] OP_MARK = 3'd5;

    // What the scan chain looks for.
    localparam int SM_W = 2;
    localparam logic [SM_W-1:0] SM_READ   = 2'd0;
    localparam logic [SM_W-1:0] SM_FIND   = 2'd1;
    localparam logic [SM_W-1:0] SM_REMOVE = 2'd2;

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [SM_W-1:0]  smode;
        logic [IDX_W-1:0] sel;
        logic [CNT_W-1:0] used;
        word_t            word;
        logic             phase;
    } olb_ctl_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] cnt;
        word_t            data;
    } olb_scan_t;

endpackage

// ===== hdl/olb_cell.sv =====
module olb_cell
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [olb_pkg::IDX_W-1:0] index,
    input  olb_pkg::olb_ctl_t         ctl,
    input  olb_pkg::word_t            below_data,
    input  logic                      below_hole,
    input  olb_pkg::word_t            above_data,
    input  logic                      above_hole,
    input  olb_pkg::olb_scan_t        scan_in,
    output olb_pkg::word_t            data,
    output logic                      hole,
    output olb_pkg::olb_scan_t        scan_out
);
    import olb_pkg::*;

    word_t     data_reg;
    word_t     data_next;
    logic      hole_reg;
    logic      hole_next;
    olb_scan_t scan_reg;
    olb_scan_t scan_next;
    logic      in_list;
    logic      match;
    logic      hit;
    logic      is_low;

    assign in_list = CNT_W'(index) < ctl.used;
    assign match   = in_list && (data_reg == ctl.word);
    // In a compaction step this cell pairs with the cell above when its low index
    // bit equals the phase, otherwise with the cell below.
    assign is_low  = index[0] == ctl.phase;

    always_comb
    begin
        if (ctl.smode == SM_READ)
        begin
            hit = index == ctl.sel;
        end
        else if (ctl.smode inside {SM_FIND, SM_REMOVE})
        begin
            hit = match;
        end
        else
        begin
            hit = 1'b0;
        end
    end

    // A hit overrides whatever arrives from above, so the lowest hit wins at the head.
    always_comb
    begin
        scan_next     = scan_in;
        scan_next.cnt = scan_in.cnt + CNT_W'(hit);
        if (hit)
        begin
            scan_next.hit  = 1'b1;
            scan_next.idx  = index;
            scan_next.data = data_reg;
        end
    end

    always_comb
    begin
        data_next = data_reg;
        hole_next = hole_reg;
        case (ctl.op)
            OP_HOLD:
            begin
                data_next = data_reg;
            end
            OP_LOAD:
            begin
                if (index == ctl.sel)
                begin
                    data_next = ctl.word;
                end
            end
            OP_INS:
            begin
                if (index == ctl.sel)
                begin
                    data_next = ctl.word;
                end
                else if (index > ctl.sel)
                begin
                    data_next = below_data;
                end
            end
            OP_DEL:
            begin
                if (index >= ctl.sel)
                begin
                    data_next = above_data;
                end
            end
            OP_MARK:
            begin
                hole_next = match || !in_list;
            end
            OP_CMP:
            begin
                if (is_low)
                begin
                    if (hole_reg && !above_hole)
                    begin
                        data_next = above_data;
                        hole_next = 1'b0;
                    end
                end
                else
                begin
                    if (!hole_reg && below_hole)
                    begin
                        data_next = below_data;
                        hole_next = 1'b1;
                    end
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        scan_reg <= scan_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hole_reg <= 1'b0;
        end
        else
        begin
            hole_reg <= hole_next;
        end
    end

    assign data     = data_reg;
    assign hole     = hole_reg;
    assign scan_out = scan_reg;

endmodule

// ===== hdl/ordered_list_buffer.sv =====
// Ordered list buffer: keeps up to CAPACITY (64) 32-bit words packed in order
// and answers one command per input transaction with exactly one result
// transaction. The words live in a row of identical cells; push and insert
// update every cell in parallel and load their result without a scan, as do
// all rejected commands (full, empty pop, bad position) and the unused command
// code. Pop, delete, read and find send a query through the cells' scan chain,
// which is one register per cell, so the answer reaches the head only once it
// has passed every cell. A remove-all that finds matches also runs odd-even
// compaction after the scan. One command is worked on at a time; s_tready is
// high while the block is idle and the result register is empty or being
// emptied in the same cycle.
`include "ordered_list_buffer_assert.svh"

module ordered_list_buffer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // From bit 0 up: cmd[2:0], position[6:0], data_in[31:0], zero fill.
    input  logic [olb_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // From bit 0 up: data_out[31:0], found_pos[6:0], status[2:0], length[6:0],
    // zero fill.
    output logic [olb_pkg::M_TDATA_W-1:0] m_tdata
);
    import olb_pkg::*;

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_COMPACT = 2'd2;
    localparam logic [1:0] ST_FINISH  = 2'd3;

    // Control registers.
    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CMD_W-1:0] cmd_reg, cmd_next;
    logic [SM_W-1:0]  smode_reg, smode_next;
    logic [IDX_W-1:0] sel_reg, sel_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    word_t            word_reg, word_next;
    logic             m_valid_reg, m_valid_next;

    // Result register.
    word_t             dout_reg, dout_next;
    logic [FPOS_W-1:0] found_reg, found_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [LEN_W-1:0]  length_reg, length_next;

    logic              out_free;
    logic              accept;
    logic              load_res;
    logic [CMD_W-1:0]  in_cmd;
    logic [POS_W-1:0]  in_pos;
    word_t             in_word;
    olb_ctl_t          ctl;
    olb_scan_t         head;

    // The row of cells, with a fixed neighbor at each end: below cell 0 sits a
    // word that is never a hole, above the last cell a hole, so no compaction
    // step moves data past either end.
    word_t     ext_data [0:CAPACITY+1];
    logic      ext_hole [0:CAPACITY+1];
    olb_scan_t scan_w   [0:CAPACITY];

    assign ext_data[0]          = '0;
    assign ext_hole[0]          = 1'b0;
    assign ext_data[CAPACITY+1] = '0;
    assign ext_hole[CAPACITY+1] = 1'b1;
    assign scan_w[CAPACITY]     = '0;
    assign head                 = scan_w[0];

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        olb_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .index      (IDX_W'(g)),
            .ctl        (ctl),
            .below_data (ext_data[g]),
            .below_hole (ext_hole[g]),
            .above_data (ext_data[g+2]),
            .above_hole (ext_hole[g+2]),
            .scan_in    (scan_w[g+1]),
            .data       (ext_data[g+1]),
            .hole       (ext_hole[g+1]),
            .scan_out   (scan_w[g])
        );
    end

    assign in_cmd  = s_tdata[CMD_W-1:0];
    assign in_pos  = s_tdata[CMD_W+POS_W-1:CMD_W];
    assign in_word = s_tdata[S_FIELDS_W-1:CMD_W+POS_W];

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        used_next   = used_reg;
        cmd_next    = cmd_reg;
        smode_next  = smode_reg;
        sel_next    = sel_reg;
        rem_next    = rem_reg;
        word_next   = word_reg;
        load_res    = 1'b0;
        dout_next   = '0;
        found_next  = NO_POS;
        status_next = ST_OK;

        ctl.op    = OP_HOLD;
        ctl.smode = smode_reg;
        ctl.sel   = sel_reg;
        ctl.used  = used_reg;
        ctl.word  = word_reg;
        ctl.phase = cnt_reg[0];

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next  = in_cmd;
                    word_next = in_word;
                    cnt_next  = '0;
                    ctl.word  = in_word;
                    case (in_cmd)
                        CMD_PUSH:
                        begin
                            load_res = 1'b1;
                            if (used_reg >= FULL_COUNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ctl.op    = OP_LOAD;
                                ctl.sel   = used_reg[IDX_W-1:0];
                                used_next = used_reg + CNT_W'(1);
                            end
                        end
                        CMD_POP:
                        begin
                            if (used_reg == '0)
                            begin
                                load_res    = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                sel_next   = IDX_W'(used_reg - CNT_W'(1));
                                smode_next = SM_READ;
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_INSERT:
                        begin
                            load_res = 1'b1;
                            if (32'(in_pos) > 32'(used_reg))
                            begin
                                status_next = ST_BADIDX;
                            end
                            else if (used_reg >= FULL_COUNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ctl.op    = OP_INS;
                                ctl.sel   = in_pos[IDX_W-1:0];
                                used_next = used_reg + CNT_W'(1);
                            end
                        end
                        CMD_DELETE, CMD_READ:
                        begin
                            if (32'(in_pos) >= 32'(used_reg))
                            begin
                                load_res    = 1'b1;
                                status_next = ST_BADIDX;
                            end
                            else
                            begin
                                sel_next   = in_pos[IDX_W-1:0];
                                smode_next = SM_READ;
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_FIND:
                        begin
                            smode_next = SM_FIND;
                            state_next = ST_SCAN;
                        end
                        CMD_REMOVE:
                        begin
                            smode_next = SM_REMOVE;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            load_res = 1'b1;
                        end
                    endcase
                    // The query reaches the cells in the accepting cycle, so every
                    // scan register holds a hit of this query from the first scan
                    // cycle on and the head is complete at the last one.
                    if (state_next == ST_SCAN)
                    begin
                        ctl.smode = smode_next;
                        ctl.sel   = sel_next;
                    end
                end
            end
            ST_SCAN:
            begin
                // A remove-all marks its holes while the match count travels to
                // the head; the other scans leave the cells alone.
                if (smode_reg == SM_REMOVE)
                begin
                    ctl.op = OP_MARK;
                end
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    rem_next = head.cnt;
                    cnt_next = '0;
                    if (cmd_reg == CMD_REMOVE && head.cnt != '0)
                    begin
                        state_next = ST_COMPACT;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_COMPACT:
            begin
                ctl.op   = OP_CMP;
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    load_res   = 1'b1;
                    state_next = ST_IDLE;
                    case (cmd_reg)
                        CMD_POP:
                        begin
                            dout_next = head.data;
                            used_next = used_reg - CNT_W'(1);
                        end
                        CMD_DELETE:
                        begin
                            dout_next = head.data;
                            ctl.op    = OP_DEL;
                            used_next = used_reg - CNT_W'(1);
                        end
                        CMD_READ:
                        begin
                            dout_next = head.data;
                        end
                        CMD_FIND:
                        begin
                            if (head.hit)
                            begin
                                found_next = FPOS_W'(head.idx);
                            end
                            else
                            begin
                                status_next = ST_NOTFOUND;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (rem_reg == '0)
                            begin
                                status_next = ST_NOTFOUND;
                            end
                            used_next = used_reg - rem_reg;
                        end
                        default:
                        begin
                            dout_next = '0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        length_next  = LEN_W'(used_next);
        m_valid_next = load_res ? 1'b1 : (m_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            used_reg    <= '0;
            cmd_reg     <= CMD_PUSH;
            smode_reg   <= SM_READ;
            sel_reg     <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            used_reg    <= used_next;
            cmd_reg     <= cmd_next;
            smode_reg   <= smode_next;
            sel_reg     <= sel_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (load_res)
        begin
            dout_reg   <= dout_next;
            found_reg  <= found_next;
            status_reg <= status_next;
            length_reg <= length_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, length_reg, status_reg, found_reg, dout_reg};

    // The count of stored words never passes the capacity.
    `OLB_ASSERT(a_used_bound, used_reg <= FULL_COUNT)

    // A full report always comes with a full list.
    `OLB_ASSERT(a_full_len, (m_valid_reg && status_reg == ST_FULL) |-> (length_reg == LEN_W'(CAPACITY)))

    // A found position is a success and lies inside the list.
    `OLB_ASSERT(a_found_pos, (m_valid_reg && found_reg != NO_POS) |-> (status_reg == ST_OK && 32'(found_reg) < 32'(length_reg)))

    // A push into a list with room grows it by exactly one word.
    `OLB_ASSERT(a_push_grow, (accept && in_cmd == CMD_PUSH && used_reg < FULL_COUNT) |=> (used_reg == $past(used_reg) + CNT_W'(1)))

    // A scan runs its full length before the head of the chain is used.
    `OLB_ASSERT(a_scan_len, (state_reg == ST_SCAN && cnt_reg != LAST_IDX) |=> (state_reg == ST_SCAN))

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

// Testbench for the ordered list buffer.
// A short table of hand-picked commands runs first, and then random
// episodes that fill the list to capacity, churn it, and drain it
// again. A shadow copy of the list predicts every result that has no typed
// expectation. Each result transaction is compared field by field with the oldest prediction.
module testbench;
    import olb_pkg::*;

    // Command code seven is not used by the block and must leave the list alone.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
    localparam logic [POS_W-1:0] POS_MAX    = '1;

    localparam int RANDOM_ITEMS = 500;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 2 * CAPACITY + 10;
    localparam int REPORT_MAX   = 10;

    // Kinds of random episodes.
    localparam int EP_FILL  = 0;
    localparam int EP_MIX   = 1;
    localparam int EP_DRAIN = 2;

    typedef struct packed {
        word_t             data_out;
        logic [FPOS_W-1:0] found_pos;
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  length;
    } list_reply_t;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] position;
        word_t            data_in;
        bit               typed;
        list_reply_t      want;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the list, updated when a command transaction is accepted.
    word_t       shadow_words [CAPACITY];
    int          shadow_count = 0;
    list_reply_t pending_replies [$];

    // A typed expectation travels beside the command that is on the bus.
    bit          row_typed = 1'b0;
    list_reply_t row_want = '0;

    stim_row_t   directed_rows [$];
    int          commands_sent = 0;
    int          replies_checked = 0;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          status_seen [8];

    ordered_list_buffer i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one command to the shadow list and returns the result it causes.
    function automatic list_reply_t apply_list_cmd(input logic [CMD_W-1:0] cmd,
                                                   input logic [POS_W-1:0] position,
                                                   input word_t word);
        list_reply_t r;
        int          pos;
        int          keep;
        bit          hit;
        r.data_out  = '0;
        r.found_pos = NO_POS;
        r.status    = ST_OK;
        pos         = int'(position);
        case (cmd)
            CMD_PUSH:
            begin
                if (shadow_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    shadow_words[shadow_count] = word;
                    shadow_count++;
                end
            end
            CMD_POP:
            begin
                if (shadow_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    shadow_count--;
                    r.data_out = shadow_words[shadow_count];
                end
            end
            CMD_INSERT:
            begin
                // A bad position wins over a full list.
                if (pos > shadow_count)
                    r.status = ST_BADIDX;
                else if (shadow_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = shadow_count; i > pos; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[pos] = word;
                    shadow_count++;
                end
            end
            CMD_DELETE:
            begin
                if (pos >= shadow_count)
                    r.status = ST_BADIDX;
                else
                begin
                    r.data_out = shadow_words[pos];
                    for (int i = pos; i + 1 < shadow_count; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_count--;
                end
            end
            CMD_FIND:
            begin
                r.status = ST_NOTFOUND;
                hit = 1'b0;
                for (int i = 0; i < shadow_count && !hit; i++)
                begin
                    if (shadow_words[i] == word)
                    begin
                        hit         = 1'b1;
                        r.found_pos = FPOS_W'(i);
                        r.status    = ST_OK;
                    end
                end
            end
            CMD_REMOVE:
            begin
                keep = 0;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_words[i] != word)
                    begin
                        shadow_words[keep] = shadow_words[i];
                        keep++;
                    end
                end
                if (keep == shadow_count)
                    r.status = ST_NOTFOUND;
                shadow_count = keep;
            end
            CMD_READ:
            begin
                if (pos >= shadow_count)
                    r.status = ST_BADIDX;
                else
                    r.data_out = shadow_words[pos];
            end
            default:
            begin
            end
        endcase
        r.length = LEN_W'(shadow_count);
        return r;
    endfunction

    function automatic list_reply_t make_reply(input word_t data_out,
                                               input logic [FPOS_W-1:0] found_pos,
                                               input logic [STAT_W-1:0] status,
                                               input int length);
        list_reply_t r;
        r.data_out  = data_out;
        r.found_pos = found_pos;
        r.status    = status;
        r.length    = LEN_W'(length);
        return r;
    endfunction

    function automatic void add_row(input logic [CMD_W-1:0] cmd,
                                    input logic [POS_W-1:0] position,
                                    input word_t data_in,
                                    input bit typed,
                                    input list_reply_t want);
        stim_row_t row;
        row.cmd      = cmd;
        row.position = position;
        row.data_in  = data_in;
        row.typed    = typed;
        row.want     = want;
        directed_rows.push_back(row);
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        else
            return $urandom_range(30, 80);
    endfunction

    // Words come from a small pool or from the list itself so that find and
    // remove-all hit often; extremes and fully random words fill the rest.
    function automatic word_t pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return word_t'($urandom_range(0, 7));
        else if (r < 60 && shadow_count > 0)
            return shadow_words[$urandom_range(0, shadow_count - 1)];
        else if (r < 70)
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return '1;
                2: return 32'h8000_0000;
                default: return 32'h0000_0001;
            endcase
        end
        else
            return $urandom;
    endfunction

    // Positions mostly land inside the list, on its end, or anywhere in the field.
    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return POS_W'($urandom_range(0, shadow_count));
        else if (r < 70)
            return POS_W'(shadow_count);
        else if (r < 90)
            return POS_W'($urandom_range(0, int'(POS_MAX)));
        else
            return r[0] ? POS_MAX : '0;
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input int kind);
        int r;
        r = $urandom_range(0, 99);
        if (kind == EP_FILL)
        begin
            if (r < 45)      return CMD_PUSH;
            else if (r < 80) return CMD_INSERT;
            else if (r < 85) return CMD_FIND;
            else if (r < 90) return CMD_READ;
            else if (r < 95) return CMD_DELETE;
            else if (r < 98) return CMD_POP;
            else             return CMD_REMOVE;
        end
        else if (kind == EP_DRAIN)
        begin
            if (r < 30)      return CMD_POP;
            else if (r < 60) return CMD_DELETE;
            else if (r < 75) return CMD_REMOVE;
            else if (r < 85) return CMD_READ;
            else if (r < 92) return CMD_FIND;
            else if (r < 97) return CMD_PUSH;
            else             return CMD_INSERT;
        end
        else
        begin
            if (r < 15)      return CMD_PUSH;
            else if (r < 30) return CMD_INSERT;
            else if (r < 42) return CMD_POP;
            else if (r < 54) return CMD_DELETE;
            else if (r < 68) return CMD_FIND;
            else if (r < 78) return CMD_REMOVE;
            else if (r < 96) return CMD_READ;
            else             return CMD_UNUSED;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the
    // command transaction has been accepted.
    task automatic issue_cmd(input logic [CMD_W-1:0] cmd,
                             input logic [POS_W-1:0] position,
                             input word_t word,
                             input bit typed,
                             input list_reply_t want,
                             input bit calm);
        int gap;
        gap = pick_gap(calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        row_typed = typed;
        row_want  = want;
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({word, position, cmd});
        do
            @(posedge clk);
        while (!s_tready);
        commands_sent++;
        @(negedge clk);
    endtask

    // One random episode: fill runs past full, drain runs past empty, and a
    // mixed episode is a random stretch of every command. No episode sends
    // past the command count given by last_cmd.
    task automatic run_episode(input int kind, input bit calm, input int last_cmd);
        logic [CMD_W-1:0] cmd;
        int               steps;
        int               extra;
        int               span;
        steps = 0;
        extra = 0;
        span  = (kind == EP_MIX) ? $urandom_range(30, 60) : 200;
        while (steps < span && extra < 6 && commands_sent < last_cmd)
        begin
            cmd = pick_command(kind);
            issue_cmd(cmd, pick_position(), pick_word(), 1'b0, '0, calm);
            steps++;
            if ((kind == EP_FILL && shadow_count == CAPACITY) ||
                (kind == EP_DRAIN && shadow_count == 0))
                extra++;
        end
    endtask

    // Check results, predict accepted commands, and watch for a hang. The
    // result side is handled first so that a command accepted in the same
    // cycle never lends its prediction to an earlier result.
    always @(posedge clk)
    begin : check_and_predict
        list_reply_t got;
        list_reply_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.data_out  = m_tdata[DATA_WIDTH-1:0];
                got.found_pos = m_tdata[DATA_WIDTH +: FPOS_W];
                got.status    = m_tdata[DATA_WIDTH + FPOS_W +: STAT_W];
                got.length    = m_tdata[DATA_WIDTH + FPOS_W + STAT_W +: LEN_W];
                status_seen[got.status]++;
                if (pending_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result with nothing expected: data %h pos %h status %0d len %0d",
                                 $realtime, got.data_out, got.found_pos, got.status, got.length);
                end
                else
                begin
                    want = pending_replies.pop_front();
                    replies_checked++;
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("%0t: result %0d: expected data %h pos %h status %0d len %0d, got data %h pos %h status %0d len %0d",
                                     $realtime, replies_checked, want.data_out, want.found_pos,
                                     want.status, want.length, got.data_out, got.found_pos,
                                     got.status, got.length);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                want = apply_list_cmd(s_tdata[CMD_W-1:0], s_tdata[CMD_W +: POS_W],
                                      s_tdata[CMD_W + POS_W +: DATA_WIDTH]);
                pending_replies.push_back(row_typed ? row_want : want);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("ordered_list_buffer test failed");
                $finish;
            end
        end
    end

    // Result side: random stalls with stretches of steady readiness.
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(100, 300)) @(negedge clk);
            end
            else
            begin
                stall = pick_gap(1'b0);
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
    end

    initial
    begin : command_source
        int  random_start;
        int  episode;
        bit  paused;
        bit  calm;
        // From reset: the empty list rejects what needs an element, and the
        // first words go in by insert into an empty list and by push.
        add_row(CMD_POP, '0, '0, 1'b1, make_reply('0, NO_POS, ST_EMPTY, 0));
        add_row(CMD_READ, '0, '0, 1'b1, make_reply('0, NO_POS, ST_BADIDX, 0));
        add_row(CMD_DELETE, '0, '0, 1'b1, make_reply('0, NO_POS, ST_BADIDX, 0));
        add_row(CMD_INSERT, 7'd1, 32'h5, 1'b1, make_reply('0, NO_POS, ST_BADIDX, 0));
        add_row(CMD_FIND, '0, '0, 1'b1, make_reply('0, NO_POS, ST_NOTFOUND, 0));
        add_row(CMD_REMOVE, '0, '0, 1'b1, make_reply('0, NO_POS, ST_NOTFOUND, 0));
        add_row(CMD_INSERT, '0, '1, 1'b1, make_reply('0, NO_POS, ST_OK, 1));
        add_row(CMD_PUSH, POS_MAX, '0, 1'b1, make_reply('0, NO_POS, ST_OK, 2));
        // Insert at the end appends, insert at zero prepends.
        add_row(CMD_INSERT, 7'd2, 32'hA5A5_A5A5, 1'b0, '0);
        add_row(CMD_INSERT, '0, '0, 1'b0, '0);
        add_row(CMD_FIND, '0, '1, 1'b0, '0);
        add_row(CMD_FIND, POS_MAX, '0, 1'b0, '0);
        add_row(CMD_READ, 7'd3, '0, 1'b0, '0);
        add_row(CMD_READ, 7'd4, '0, 1'b0, '0);
        add_row(CMD_UNUSED, POS_MAX, '1, 1'b0, '0);
        add_row(CMD_DELETE, 7'd1, '0, 1'b0, '0);
        // Two zero words are in the list; remove-all drops both.
        add_row(CMD_REMOVE, '0, '0, 1'b0, '0);
        add_row(CMD_FIND, '0, 32'h1234_5678, 1'b0, '0);
        add_row(CMD_POP, '0, '0, 1'b0, '0);
        add_row(CMD_DELETE, POS_MAX, '0, 1'b0, '0);
        add_row(CMD_READ, '0, '0, 1'b0, '0);
        add_row(CMD_POP, '0, '0, 1'b0, '0);
        add_row(CMD_POP, '0, '0, 1'b0, '0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[k])
            issue_cmd(directed_rows[k].cmd, directed_rows[k].position,
                      directed_rows[k].data_in, directed_rows[k].typed,
                      directed_rows[k].want, 1'b0);

        // Random episodes cycle through fill, mix, drain, mix.
        random_start = commands_sent;
        episode      = 0;
        paused       = 1'b0;
        while (commands_sent - random_start < RANDOM_ITEMS)
        begin
            calm = ($urandom_range(0, 3) == 0);
            case (episode % 4)
                0:       run_episode(EP_FILL, calm, random_start + RANDOM_ITEMS);
                2:       run_episode(EP_DRAIN, calm, random_start + RANDOM_ITEMS);
                default: run_episode(EP_MIX, calm, random_start + RANDOM_ITEMS);
            endcase
            // Once, halfway through, hold off until every result is back.
            if (!paused && commands_sent - random_start >= RANDOM_ITEMS / 2)
            begin
                s_tvalid <= 1'b0;
                while (pending_replies.size() != 0)
                    @(negedge clk);
                paused = 1'b1;
            end
            episode++;
        end
        s_tvalid <= 1'b0;

        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d commands and %0d results: %0d full, %0d empty, %0d bad position, %0d not found.",
                 commands_sent, replies_checked, status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_BADIDX], status_seen[ST_NOTFOUND]);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("ordered_list_buffer test passed");
        else
            $display("ordered_list_buffer test failed");
        $finish;
    end

endmodule
